[rtl/core/scc_pkg.sv]
// Shared widths and constants for the sphere/capsule contact block.
// Used by every module in rtl/core; depends on nothing.
package scc_pkg;

    localparam int MUL_W   = 34;           // signed operand width of the shared multiplier
    localparam int PROD_W  = 2 * MUL_W;    // full product width
    localparam int RAD_W   = 64;           // square root radicand width
    localparam int ROOT_W  = RAD_W / 2;    // square root result width
    localparam int MAG_W   = 33;           // magnitude of one offset component
    localparam int DIST_W  = 34;           // distance after the range shift
    localparam int QUO_W   = 32;           // quotient bits produced by the divider
    localparam int ITER_W  = 5;            // iteration counter width (32 steps)

    localparam logic [RAD_W-1:0] ROOT_BIT0 = RAD_W'(1) << (RAD_W - 2);
    localparam logic [QUO_W-1:0] Q30_ONE   = QUO_W'(1) << 30;

endpackage

[rtl/core/scc_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on scc_pkg for operand and product widths.
module scc_mul (
    input  logic                                i_clk,
    input  logic signed [scc_pkg::MUL_W-1:0]    i_a,
    input  logic signed [scc_pkg::MUL_W-1:0]    i_b,
    output logic signed [scc_pkg::PROD_W-1:0]   o_prod
);

    logic signed [scc_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[rtl/core/scc_root.sv]
// Iterative floor square root of a 64-bit radicand, one result bit per cycle.
// Depends on scc_pkg for widths and the starting bit.
module scc_root (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [scc_pkg::RAD_W-1:0]       i_rad,
    output logic                            o_done,
    output logic [scc_pkg::ROOT_W-1:0]      o_root
);

    logic [scc_pkg::RAD_W-1:0]  r_n;
    logic [scc_pkg::RAD_W-1:0]  r_res;
    logic [scc_pkg::RAD_W-1:0]  r_bit;
    logic [scc_pkg::ITER_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [scc_pkg::RAD_W-1:0]  w_try;

    assign w_try = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_rad;
            r_res <= '0;
            r_bit <= scc_pkg::ROOT_BIT0;
        end else if (r_busy) begin
            if (r_n >= w_try) begin
                r_n   <= r_n - w_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[scc_pkg::ROOT_W-1:0];

endmodule

[rtl/core/scc_div.sv]
// Restoring divider for (mag << 30) / den, one quotient bit per cycle.
// The caller guarantees mag >> 2 < den. Depends on scc_pkg for widths.
module scc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [scc_pkg::MAG_W-1:0]       i_mag,
    input  logic [scc_pkg::DIST_W-1:0]      i_den,
    output logic                            o_done,
    output logic [scc_pkg::QUO_W-1:0]       o_quo
);

    logic [scc_pkg::DIST_W-1:0] r_rem;
    logic [scc_pkg::DIST_W-1:0] r_den;
    logic [scc_pkg::QUO_W-1:0]  r_lo;
    logic [scc_pkg::QUO_W-1:0]  r_quo;
    logic [scc_pkg::ITER_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [scc_pkg::DIST_W:0]   w_sh;
    logic                       w_ge;

    assign w_sh = {r_rem, r_lo[scc_pkg::QUO_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= scc_pkg::DIST_W'(i_mag >> 2);
            r_lo  <= {i_mag[1:0], 30'b0};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= scc_pkg::DIST_W'(w_sh - {1'b0, r_den});
            end else begin
                r_rem <= w_sh[scc_pkg::DIST_W-1:0];
            end
            r_lo  <= r_lo << 1;
            r_quo <= {r_quo[scc_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[rtl/core/sphere_capsule_contact_top.sv]
// Sphere/capsule signed-distance contact. A sphere item stores the sphere and gives no output.
// A capsule item runs 21 multiplies on the shared multiplier, a range shift, a square root,
// three divides (skipped when the distance is zero) and one output load, which waits until the
// output register is free. The block takes one item at a time and is ready again in the cycle
// after the load, so no new item is taken while a capsule item is in progress.
// Synchronous active-low reset clears the sequencer, output valid and held sphere.
module sphere_capsule_contact_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // pos_x, pos_y, pos_z, body_radius, body_length, quat_w, quat_x, quat_y,
    // quat_z, two zero pad bits
    input  logic [287:0]  i_s_tdata,
    // op
    input  logic [0:0]    i_s_tuser,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // separation, normal_x, normal_y, normal_z, sphere_point_x, sphere_point_y,
    // sphere_point_z, capsule_point_x, capsule_point_y, capsule_point_z
    output logic [319:0]  o_m_tdata,
    // degenerate
    output logic [0:0]    o_m_tuser
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_KSH   = 3'd2;
    localparam logic [2:0] S_ROOT  = 3'd3;
    localparam logic [2:0] S_RWAIT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DWAIT = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic signed [67:0] ONE68 = 68'sd1073741824;

    // Clamp to the Q2.30 range [-1.0, 1.0].
    function automatic logic signed [31:0] clamp_q30(input logic signed [67:0] x);
        if (x > ONE68) begin
            return 32'sh4000_0000;
        end else if (x < -ONE68) begin
            return -32'sh4000_0000;
        end
        return x[31:0];
    endfunction

    // Saturate to 32 bits signed.
    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > 68'sh7fff_ffff) begin
            return 32'sh7fff_ffff;
        end else if (x < -68'sh8000_0000) begin
            return -32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [67:0] ext32(input logic signed [31:0] x);
        return {{36{x[31]}}, x};
    endfunction

    // Sequencer.
    logic [2:0]  r_state;
    logic [4:0]  r_step;
    logic        r_ph;
    logic [1:0]  r_di;
    logic        r_ov;

    // Held sphere (reset to zero) and capsule operands.
    logic signed [31:0] r_p [3];
    logic [30:0]        r_rs;
    logic signed [31:0] r_c [3];
    logic [30:0]        r_rc;
    logic [29:0]        r_half;
    logic signed [31:0] r_qw, r_qx, r_qy, r_qz;

    // Intermediate results.
    logic signed [67:0] r_acc;
    logic signed [31:0] r_t [3];
    logic signed [31:0] r_u;
    logic signed [32:0] r_a [3];
    logic [2:0]         r_neg;
    logic [32:0]        r_m [3];
    logic [30:0]        r_ms [3];
    logic [1:0]         r_k;
    logic [63:0]        r_sum;
    logic [33:0]        r_dist;
    logic signed [31:0] r_n [3];
    logic signed [31:0] r_sp [3];
    logic signed [31:0] r_cp [3];

    logic [319:0]       r_odata;
    logic               r_ouser;

    logic               w_acc_in;
    logic               w_op;
    logic               w_out_load;
    logic [1:0]         w_idx;
    logic signed [33:0] w_ma, w_mb;
    logic signed [67:0] w_prod;
    logic signed [67:0] w_shr30, w_sum29, w_dif29, w_uacc, w_h68, w_a68;
    logic signed [33:0] w_v;
    logic [33:0]        w_mag;
    logic signed [32:0] w_w;
    logic [32:0]        w_mx;
    logic [1:0]         w_k;
    logic               w_root_done, w_div_done;
    logic [31:0]        w_root, w_quo, w_q;
    logic [33:0]        w_dist;
    logic signed [67:0] w_sep;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc_in   = i_s_tvalid && o_s_tready;
    assign w_op       = i_s_tuser[0];
    assign w_out_load = (r_state == S_OUT) && (!r_ov || i_m_tready);

    // Component index for the per-axis multiply steps.
    always_comb begin
        case (r_step) inside
            [5'd6:5'd8]:   w_idx = 2'(r_step - 5'd6);
            [5'd9:5'd11]:  w_idx = 2'(r_step - 5'd9);
            [5'd12:5'd14]: w_idx = 2'(r_step - 5'd12);
            [5'd15:5'd20]: w_idx = 2'((r_step - 5'd15) >> 1);
            default:       w_idx = 2'd0;
        endcase
    end

    assign w_w = {r_p[w_idx][31], r_p[w_idx]} - {r_c[w_idx][31], r_c[w_idx]};

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_step) inside
            5'd0:          begin w_ma = 34'(r_qy); w_mb = 34'(r_qy); end
            5'd1:          begin w_ma = 34'(r_qz); w_mb = 34'(r_qz); end
            5'd2:          begin w_ma = 34'(r_qx); w_mb = 34'(r_qy); end
            5'd3:          begin w_ma = 34'(r_qw); w_mb = 34'(r_qz); end
            5'd4:          begin w_ma = 34'(r_qx); w_mb = 34'(r_qz); end
            5'd5:          begin w_ma = 34'(r_qw); w_mb = 34'(r_qy); end
            [5'd6:5'd8]:   begin w_ma = 34'(w_w); w_mb = 34'(r_t[w_idx]); end
            [5'd9:5'd11]:  begin w_ma = 34'(r_u); w_mb = 34'(r_t[w_idx]); end
            [5'd12:5'd14]: begin
                w_ma = $signed({3'b0, r_ms[w_idx]});
                w_mb = $signed({3'b0, r_ms[w_idx]});
            end
            [5'd15:5'd20]: begin
                w_ma = r_step[0] ? $signed({3'b0, r_rs}) : $signed({3'b0, r_rc});
                w_mb = 34'(r_n[w_idx]);
            end
            default:       begin w_ma = '0; w_mb = '0; end
        endcase
    end

    scc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    // Floor shifts of the product and the axis point for the current component.
    assign w_shr30 = w_prod >>> 30;
    assign w_sum29 = (r_acc + w_prod) >>> 29;
    assign w_dif29 = (r_acc - w_prod) >>> 29;
    assign w_uacc  = r_acc + w_shr30;
    assign w_h68   = $signed({38'b0, r_half});
    assign w_a68   = ext32(r_c[w_idx]) + w_shr30;
    assign w_v     = {w_a68[32], w_a68[32:0]} - {{2{r_p[w_idx][31]}}, r_p[w_idx]};
    assign w_mag   = w_v[33] ? 34'(-w_v) : 34'(w_v);

    // Range shift that brings every magnitude under 2^31.
    always_comb begin
        w_mx = r_m[0];
        if (r_m[1] > w_mx) begin
            w_mx = r_m[1];
        end
        if (r_m[2] > w_mx) begin
            w_mx = r_m[2];
        end
        if (w_mx[32]) begin
            w_k = 2'd2;
        end else if (w_mx[31]) begin
            w_k = 2'd1;
        end else begin
            w_k = 2'd0;
        end
    end

    scc_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ROOT),
        .i_rad   (r_sum),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    scc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV),
        .i_mag   (r_m[r_di]),
        .i_den   (r_dist),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_dist = {2'b0, w_root} << r_k;
    assign w_q    = (w_quo > scc_pkg::Q30_ONE) ? scc_pkg::Q30_ONE : w_quo;
    assign w_sep  = $signed({34'b0, r_dist}) - $signed({37'b0, r_rs})
                  - $signed({37'b0, r_rc});

    // Control state and the held sphere.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_ph    <= 1'b0;
            r_di    <= '0;
            r_ov    <= 1'b0;
            r_p[0]  <= '0;
            r_p[1]  <= '0;
            r_p[2]  <= '0;
            r_rs    <= '0;
        end else begin
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        if (!w_op) begin
                            r_p[0] <= i_s_tdata[31:0];
                            r_p[1] <= i_s_tdata[63:32];
                            r_p[2] <= i_s_tdata[95:64];
                            r_rs   <= i_s_tdata[126:96];
                        end else begin
                            r_state <= S_MUL;
                            r_step  <= '0;
                            r_ph    <= 1'b0;
                        end
                    end
                end
                S_MUL: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_step <= r_step + 1'b1;
                        if (r_step == 5'd11) begin
                            r_state <= S_KSH;
                        end else if (r_step == 5'd14) begin
                            r_state <= S_ROOT;
                        end else if (r_step == 5'd20) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_KSH:  r_state <= S_MUL;
                S_ROOT: r_state <= S_RWAIT;
                S_RWAIT: begin
                    if (w_root_done) begin
                        if (w_root == '0) begin
                            r_state <= S_MUL;
                        end else begin
                            r_di    <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_div_done) begin
                        if (r_di == 2'd2) begin
                            r_state <= S_MUL;
                        end else begin
                            r_di    <= r_di + 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_acc_in && w_op) begin
            r_c[0] <= i_s_tdata[31:0];
            r_c[1] <= i_s_tdata[63:32];
            r_c[2] <= i_s_tdata[95:64];
            r_rc   <= i_s_tdata[126:96];
            r_half <= i_s_tdata[157:128];
            r_qw   <= clamp_q30(ext32(i_s_tdata[189:158]));
            r_qx   <= clamp_q30(ext32(i_s_tdata[221:190]));
            r_qy   <= clamp_q30(ext32(i_s_tdata[253:222]));
            r_qz   <= clamp_q30(ext32(i_s_tdata[285:254]));
        end
        if (r_state == S_MUL && r_ph) begin
            case (r_step) inside
                5'd0, 5'd2, 5'd4: r_acc <= w_prod;
                5'd1:  r_t[0] <= clamp_q30(ONE68 - w_sum29);
                5'd3:  r_t[1] <= clamp_q30(w_sum29);
                5'd5:  r_t[2] <= clamp_q30(w_dif29);
                5'd6:  r_acc <= w_shr30;
                5'd7:  r_acc <= w_uacc;
                5'd8: begin
                    if (w_uacc > w_h68) begin
                        r_u <= $signed({2'b0, r_half});
                    end else if (w_uacc < -w_h68) begin
                        r_u <= -$signed({2'b0, r_half});
                    end else begin
                        r_u <= w_uacc[31:0];
                    end
                end
                [5'd9:5'd11]: begin
                    r_a[w_idx]   <= w_a68[32:0];
                    r_neg[w_idx] <= w_v[33];
                    r_m[w_idx]   <= w_mag[32:0];
                end
                5'd12: r_sum <= w_prod[63:0];
                [5'd13:5'd14]: r_sum <= r_sum + w_prod[63:0];
                [5'd15:5'd20]: begin
                    if (r_step[0]) begin
                        r_sp[w_idx] <= sat32(ext32(r_p[w_idx]) + w_shr30);
                    end else begin
                        r_cp[w_idx] <= sat32({{35{r_a[w_idx][32]}}, r_a[w_idx]} - w_shr30);
                    end
                end
                default: r_acc <= r_acc;
            endcase
        end
        if (r_state == S_KSH) begin
            r_k     <= w_k;
            r_ms[0] <= 31'(r_m[0] >> w_k);
            r_ms[1] <= 31'(r_m[1] >> w_k);
            r_ms[2] <= 31'(r_m[2] >> w_k);
        end
        if (r_state == S_RWAIT && w_root_done) begin
            r_dist <= w_dist;
            if (w_root == '0) begin
                r_n[0] <= '0;
                r_n[1] <= '0;
                r_n[2] <= '0;
            end
        end
        if (r_state == S_DWAIT && w_div_done) begin
            r_n[r_di] <= r_neg[r_di] ? -$signed(w_q) : $signed(w_q);
        end
        if (w_out_load) begin
            r_odata <= {r_cp[2], r_cp[1], r_cp[0], r_sp[2], r_sp[1], r_sp[0],
                        r_n[2], r_n[1], r_n[0], sat32(w_sep)};
            r_ouser <= (r_dist == '0);
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule
